@@ rtl/pod_pkg.sv @@
// Shared types and constants for the page owner lookup block.
`timescale 1ns / 1ps

package pod_pkg;

  // Fixed register widths
  localparam int MODE_W    = 2;
  localparam int ARG_W     = 21;
  localparam int NCNT_W    = 9;
  localparam int RANK_W    = 8;
  localparam int REG_IDX_W = 3;

  // Register indexes of the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_MODE_ARG   = 3'd1,
    REG_NODE_COUNT = 3'd2,
    REG_LOCAL_RANK = 3'd3,
    REG_PAGE_COUNT = 3'd4
  } pod_reg_e;

  // Distribution modes; the remaining code behaves as block mode
  localparam logic [MODE_W-1:0] MODE_CENTRAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CYCLIC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BLOCK   = 2'd2;

  // Block split derived from page and node counts
  typedef struct packed {
    logic [ARG_W-1:0]  run_len;     // pages in a short run
    logic [ARG_W-1:0]  run_len_p1;  // pages in a long run
    logic [ARG_W-1:0]  head;        // pages covered by all long runs
    logic [NCNT_W-1:0] long_runs;   // number of long runs
  } pod_split_t;

endpackage

@@ rtl/page_owner_distribution_top.sv @@
// Page owner lookup: maps a page index to its owning node in three modes.
// Pipeline: front stage, quotient cell chain, join stage, modulo cell chain and output
// register; the two cell chains handle one bit per cell.
// Throughput: one page index per cycle unless the output stalls; after each write to a
// known register input is held off while the block split is recomputed.
// Reset: asynchronous active low; pipeline empties, registers take reset values.
`timescale 1ns / 1ps

module page_owner_distribution_top
  import pod_pkg::*;
#(
  parameter int INDEX_BITS = 20,
  parameter int NODE_BITS  = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]                  cfg_index_i,
  input  logic [ARG_W-1:0]                      cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // page_index
  input  logic [((INDEX_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // owner_node, local_write, out_of_range
  output logic [((NODE_BITS+2+7)/8)*8-1:0]      m_axis_tdata
);

  localparam int OFF_W = (NODE_BITS > NCNT_W) ? NODE_BITS : NCNT_W;
  localparam int SUM_W = ((INDEX_BITS > OFF_W) ? INDEX_BITS : OFF_W) + 1;
  localparam int MD_W  = (NODE_BITS + 1 > NCNT_W) ? NODE_BITS + 1 : NCNT_W;
  localparam int M_W   = ((NODE_BITS + 2 + 7) / 8) * 8;
  localparam int TAG_W = OFF_W + 1;
  localparam logic [32:0] NODE_LIM = 33'd1 << NODE_BITS;
  localparam logic [32:0] PAGE_LIM = 33'd1 << INDEX_BITS;

  // Configuration registers
  logic [MODE_W-1:0] mode_q;
  logic [ARG_W-1:0]  arg_q;
  logic [NCNT_W-1:0] ncnt_q;
  logic [RANK_W-1:0] rank_q;
  logic [ARG_W-1:0]  pcnt_q;
  logic              cfg_hit;
  logic              split_start_q;
  logic              split_busy;
  pod_split_t        spl;
  logic [NCNT_W-1:0] eff_nodes;
  logic [ARG_W-1:0]  eff_pages;

  // Front stage
  logic [INDEX_BITS-1:0] idx;
  logic                  oor;
  logic [INDEX_BITS-1:0] f_num_d;
  logic [ARG_W-1:0]      f_div_d;
  logic [OFF_W-1:0]      f_off_d;
  logic                  f_valid_q;
  logic [INDEX_BITS-1:0] f_num_q;
  logic [ARG_W-1:0]      f_div_q;
  logic [TAG_W-1:0]      f_tag_q;
  logic                  f_ready;

  // Quotient chain links
  logic [INDEX_BITS:0]   dv_valid;
  logic [INDEX_BITS:0]   dv_ready;
  logic [ARG_W-1:0]      dv_rem [INDEX_BITS+1];
  logic [INDEX_BITS-1:0] dv_num [INDEX_BITS+1];
  logic [INDEX_BITS-1:0] dv_quo [INDEX_BITS+1];
  logic [ARG_W-1:0]      dv_div [INDEX_BITS+1];
  logic [TAG_W-1:0]      dv_tag [INDEX_BITS+1];

  // Join stage
  logic             j_valid_q;
  logic [SUM_W-1:0] j_num_q;
  logic [MD_W-1:0]  j_div_q;
  logic             j_oor_q;
  logic             j_ready;

  // Modulo chain links
  logic [SUM_W:0]   md_valid;
  logic [SUM_W:0]   md_ready;
  logic [MD_W-1:0]  md_rem [SUM_W+1];
  logic [SUM_W-1:0] md_num [SUM_W+1];
  logic [SUM_W-1:0] md_quo [SUM_W+1];
  logic [MD_W-1:0]  md_div [SUM_W+1];
  logic [0:0]       md_tag [SUM_W+1];

  // Output stage
  logic                 o_valid_q;
  logic [NODE_BITS-1:0] o_owner_q;
  logic                 o_lw_q;
  logic                 o_oor_q;
  logic                 o_ready;
  logic [NODE_BITS-1:0] owner_d;
  logic                 oor_d;

  // ---------------------------------------------------------------------------
  // Register writes; a write to a known register restarts the block split
  assign cfg_hit = cfg_we_i && (cfg_index_i <= REG_PAGE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_BLOCK;
      arg_q         <= '0;
      ncnt_q        <= NCNT_W'(1);
      rank_q        <= '0;
      pcnt_q        <= '0;
      split_start_q <= 1'b0;
    end else begin
      split_start_q <= cfg_hit;
      if (cfg_we_i) begin
        case (pod_reg_e'(cfg_index_i))
          REG_MODE:       mode_q <= cfg_data_i[MODE_W-1:0];
          REG_MODE_ARG:   arg_q  <= cfg_data_i;
          REG_NODE_COUNT: ncnt_q <= cfg_data_i[NCNT_W-1:0];
          REG_LOCAL_RANK: rank_q <= cfg_data_i[RANK_W-1:0];
          REG_PAGE_COUNT: pcnt_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Clamp node and page counts to what the index and node widths can hold
  always_comb begin
    if (ncnt_q == '0) begin
      eff_nodes = NCNT_W'(1);
    end else if (33'(ncnt_q) > NODE_LIM) begin
      eff_nodes = NCNT_W'(NODE_LIM);
    end else begin
      eff_nodes = ncnt_q;
    end
    if (33'(pcnt_q) > PAGE_LIM) begin
      eff_pages = ARG_W'(PAGE_LIM);
    end else begin
      eff_pages = pcnt_q;
    end
  end

  pod_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (split_start_q),
    .eff_pages_i (eff_pages),
    .eff_nodes_i (eff_nodes),
    .busy_o      (split_busy),
    .split_o     (spl)
  );

  // ---------------------------------------------------------------------------
  // Front stage: pick dividend, divisor and owner offset for the mode
  assign idx = s_axis_tdata[INDEX_BITS-1:0];
  assign oor = 33'(idx) >= 33'(pcnt_q);

  always_comb begin
    f_num_d = idx;
    f_div_d = ARG_W'(1);
    f_off_d = '0;
    if (mode_q == MODE_CENTRAL) begin
      // Quotient of zero plus the fixed owner
      f_num_d = '0;
      f_off_d = OFF_W'(arg_q[NODE_BITS-1:0]);
    end else if (mode_q == MODE_CYCLIC) begin
      f_div_d = (arg_q == '0) ? ARG_W'(1) : arg_q;
    end else if (33'(idx) < 33'(spl.head)) begin
      f_div_d = spl.run_len_p1;
    end else begin
      // Short runs follow the long ones; a zero run length only shows up out of range
      f_num_d = INDEX_BITS'(33'(idx) - 33'(spl.head));
      f_div_d = spl.run_len;
      f_off_d = OFF_W'(spl.long_runs);
    end
  end

  assign f_ready       = !f_valid_q || dv_ready[0];
  assign s_axis_tready = f_ready && !split_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (f_ready) begin
      f_valid_q <= s_axis_tvalid && !split_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      f_num_q <= f_num_d;
      f_div_q <= f_div_d;
      f_tag_q <= {oor, f_off_d};
    end
  end

  // ---------------------------------------------------------------------------
  // Quotient chain, one dividend bit per cell
  assign dv_valid[0] = f_valid_q;
  assign dv_rem[0]   = '0;
  assign dv_num[0]   = f_num_q;
  assign dv_quo[0]   = '0;
  assign dv_div[0]   = f_div_q;
  assign dv_tag[0]   = f_tag_q;

  for (genvar k = 0; k < INDEX_BITS; k++) begin : g_dv
    pod_cell #(
      .NUM_W (INDEX_BITS),
      .DIV_W (ARG_W),
      .TAG_W (TAG_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_valid[k]),
      .in_ready_o  (dv_ready[k]),
      .in_rem_i    (dv_rem[k]),
      .in_num_i    (dv_num[k]),
      .in_quo_i    (dv_quo[k]),
      .in_div_i    (dv_div[k]),
      .in_tag_i    (dv_tag[k]),
      .out_valid_o (dv_valid[k+1]),
      .out_ready_i (dv_ready[k+1]),
      .out_rem_o   (dv_rem[k+1]),
      .out_num_o   (dv_num[k+1]),
      .out_quo_o   (dv_quo[k+1]),
      .out_div_o   (dv_div[k+1]),
      .out_tag_o   (dv_tag[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Join stage: add the owner offset and pick the modulus
  assign j_ready              = !j_valid_q || md_ready[0];
  assign dv_ready[INDEX_BITS] = j_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_valid_q <= 1'b0;
    end else if (j_ready) begin
      j_valid_q <= dv_valid[INDEX_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_valid[INDEX_BITS] && j_ready) begin
      j_num_q <= SUM_W'(dv_quo[INDEX_BITS]) + SUM_W'(dv_tag[INDEX_BITS][OFF_W-1:0]);
      j_oor_q <= dv_tag[INDEX_BITS][OFF_W];
      // Only cyclic mode wraps over the nodes; other owners already fit
      j_div_q <= (mode_q == MODE_CYCLIC) ? MD_W'(eff_nodes) : MD_W'(NODE_LIM);
    end
  end

  // ---------------------------------------------------------------------------
  // Modulo chain, remainder by node count in cyclic mode and by 2**NODE_BITS otherwise
  assign md_valid[0] = j_valid_q;
  assign md_rem[0]   = '0;
  assign md_num[0]   = j_num_q;
  assign md_quo[0]   = '0;
  assign md_div[0]   = j_div_q;
  assign md_tag[0]   = j_oor_q;

  for (genvar k = 0; k < SUM_W; k++) begin : g_md
    pod_cell #(
      .NUM_W (SUM_W),
      .DIV_W (MD_W),
      .TAG_W (1)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (md_valid[k]),
      .in_ready_o  (md_ready[k]),
      .in_rem_i    (md_rem[k]),
      .in_num_i    (md_num[k]),
      .in_quo_i    (md_quo[k]),
      .in_div_i    (md_div[k]),
      .in_tag_i    (md_tag[k]),
      .out_valid_o (md_valid[k+1]),
      .out_ready_i (md_ready[k+1]),
      .out_rem_o   (md_rem[k+1]),
      .out_num_o   (md_num[k+1]),
      .out_quo_o   (md_quo[k+1]),
      .out_div_o   (md_div[k+1]),
      .out_tag_o   (md_tag[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: drop the owner for pages out of range
  assign o_ready         = !o_valid_q || m_axis_tready;
  assign md_ready[SUM_W] = o_ready;
  assign oor_d           = md_tag[SUM_W][0];
  assign owner_d         = oor_d ? '0 : md_rem[SUM_W][NODE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_ready) begin
      o_valid_q <= md_valid[SUM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (md_valid[SUM_W] && o_ready) begin
      o_owner_q <= owner_d;
      o_oor_q   <= oor_d;
      o_lw_q    <= !oor_d && (33'(owner_d) == 33'(rank_q));
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = M_W'({o_oor_q, o_lw_q, o_owner_q});

  // ---------------------------------------------------------------------------
  // Checks

  // A write to a known register holds off new transactions while the split is rebuilt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> !s_axis_tready)
    else $error("transaction accepted during block split recompute");

  // Out-of-range pages carry no owner and no write access
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && o_oor_q) |-> (o_owner_q == '0 && !o_lw_q))
    else $error("out-of-range page reported with an owner");

  // Centralized mode always returns the configured owner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !o_oor_q && mode_q == MODE_CENTRAL) |->
      (o_owner_q == arg_q[NODE_BITS-1:0]))
    else $error("centralized owner mismatch");

  // Cyclic owners stay below the node count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !o_oor_q && mode_q == MODE_CYCLIC) |->
      (33'(o_owner_q) < 33'(eff_nodes)))
    else $error("cyclic owner beyond node count");

endmodule

@@ rtl/pod_cell.sv @@
// One restoring division step with a registered output stage.
`timescale 1ns / 1ps

module pod_cell #(
  parameter int NUM_W = 20,
  parameter int DIV_W = 21,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DIV_W-1:0] in_rem_i,
  input  logic [NUM_W-1:0] in_num_i,
  input  logic [NUM_W-1:0] in_quo_i,
  input  logic [DIV_W-1:0] in_div_i,
  input  logic [TAG_W-1:0] in_tag_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DIV_W-1:0] out_rem_o,
  output logic [NUM_W-1:0] out_num_o,
  output logic [NUM_W-1:0] out_quo_o,
  output logic [DIV_W-1:0] out_div_o,
  output logic [TAG_W-1:0] out_tag_o
);

  logic [DIV_W:0]   trial;
  logic             fits;
  logic [DIV_W-1:0] rem_d;
  logic             valid_q;
  logic [DIV_W-1:0] rem_q;
  logic [NUM_W-1:0] num_q;
  logic [NUM_W-1:0] quo_q;
  logic [DIV_W-1:0] div_q;
  logic [TAG_W-1:0] tag_q;

  // Shift in the next dividend bit and try to subtract the divisor
  assign trial = {in_rem_i, in_num_i[NUM_W-1]};
  assign fits  = trial >= {1'b0, in_div_i};
  assign rem_d = fits ? DIV_W'(trial - {1'b0, in_div_i}) : trial[DIV_W-1:0];

  // Advance when this stage is empty or its content moves on
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q <= rem_d;
      num_q <= {in_num_i[NUM_W-2:0], 1'b0};
      quo_q <= {in_quo_i[NUM_W-2:0], fits};
      div_q <= in_div_i;
      tag_q <= in_tag_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rem_o   = rem_q;
  assign out_num_o   = num_q;
  assign out_quo_o   = quo_q;
  assign out_div_o   = div_q;
  assign out_tag_o   = tag_q;

endmodule

@@ rtl/pod_split.sv @@
// Iterative block split: divides the page count by the node count after a write.
`timescale 1ns / 1ps

module pod_split
  import pod_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ARG_W-1:0]  eff_pages_i,
  input  logic [NCNT_W-1:0] eff_nodes_i,
  output logic              busy_o,
  output pod_split_t        split_o
);

  localparam int CNT_W = $clog2(ARG_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIX,
    S_HEAD
  } state_e;

  state_e                   state_q;
  logic [ARG_W-1:0]         num_q;
  logic [ARG_W-1:0]         quo_q;
  logic [NCNT_W-1:0]        rem_q;
  logic [CNT_W-1:0]         cnt_q;
  pod_split_t               split_q;
  logic [NCNT_W:0]          trial;
  logic                     fits;
  logic [NCNT_W-1:0]        rem_d;
  logic [NCNT_W+ARG_W-1:0]  head_prod;

  // One quotient bit per cycle
  assign trial = {rem_q, num_q[ARG_W-1]};
  assign fits  = trial >= {1'b0, eff_nodes_i};
  assign rem_d = fits ? NCNT_W'(trial - {1'b0, eff_nodes_i}) : trial[NCNT_W-1:0];

  assign head_prod = split_q.long_runs * split_q.run_len_p1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      num_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      split_q <= '0;
    end else if (start_i) begin
      // Restart on every write to a known register
      state_q <= S_DIV;
      num_q   <= eff_pages_i;
      quo_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_DIV: begin
          rem_q <= rem_d;
          num_q <= {num_q[ARG_W-2:0], 1'b0};
          quo_q <= {quo_q[ARG_W-2:0], fits};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(ARG_W - 1)) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          // No pages give no long runs; an exact split keeps all runs long; otherwise leftovers go to low nodes
          if (eff_pages_i == '0) begin
            split_q.run_len    <= '0;
            split_q.run_len_p1 <= ARG_W'(1);
            split_q.long_runs  <= '0;
          end else if (rem_q == '0) begin
            split_q.run_len    <= quo_q - 1'b1;
            split_q.run_len_p1 <= quo_q;
            split_q.long_runs  <= eff_nodes_i;
          end else begin
            split_q.run_len    <= quo_q;
            split_q.run_len_p1 <= quo_q + 1'b1;
            split_q.long_runs  <= rem_q;
          end
          state_q <= S_HEAD;
        end
        S_HEAD: begin
          split_q.head <= head_prod[ARG_W-1:0];
          state_q      <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o  = start_i || (state_q != S_IDLE);
  assign split_o = split_q;

endmodule
